FILE: rtl/fed_pkg.sv
// fed_pkg: shared constants for the feedback echo delay block.
// Register index codes, Q1.15 gain limits and rounding constants.
// No dependencies.
package fed_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 18;
    localparam int DELAY_W     = 18;
    localparam int FB_W        = 15;
    localparam int MIX_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIX      = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET    = 18'd24000;
    localparam logic [FB_W-1:0]    FEEDBACK_RESET = 15'd16384;
    localparam logic [MIX_W-1:0]   MIX_RESET      = 16'd16384;

    localparam logic [FB_W-1:0]  FB_CAP = 15'd32440;
    localparam logic [MIX_W-1:0] UNITY  = 16'd32768;

    localparam int Q_SHIFT    = 15;
    localparam int ROUND_BIAS = 16384;
    localparam int CH_SLOTS   = 2;

endpackage

FILE: rtl/feedback_echo_delay_core.sv
// feedback_echo_delay_core: per-channel feedback echo with dry/wet mix.
// Holds the delay memory, write positions, pipeline and config registers.
// Depends on fed_pkg and fed_mix.
//
// Usage:
//   Input channel: in_valid with channel_index and sample_in; a transfer
//   happens on a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid with sample_out; a transfer happens on an
//   edge with out_valid high and out_stall low. One result per input.
//   Config: cfg_write, cfg_index, cfg_data write one register per edge
//   (0 delay, 1 feedback gain, 2 mix gain); write only while idle.
//   Path: stage-one registers, product registers, then the output register.
//   Throughput: one sample per cycle while in_stall is low; the delay memory takes one read at
//   input transfer and one write-back as a result enters the output register.
//   Reset: the memory is swept to zero, one entry per cycle, over all
//   DEPTH = NCH * MAX_DELAY entries (262144 at the defaults, two channels);
//   in_stall stays high during the sweep. Config writes are taken at once.
//   Receiver stall: the output register holds; bubbles in the pipeline
//   close up, then in_stall rises once all three stages are full.
module feedback_echo_delay_core #(
    parameter int MAX_DELAY   = 131072,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 channel_index,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_BITS-1:0]        sample_out,
    input  logic                                 cfg_write,
    input  logic [fed_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fed_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int NCH   = (CHANNELS > 1) ? 2 : 1;
    localparam int DEPTH = NCH * MAX_DELAY;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_DELAY);
    localparam int LW    = $clog2(MAX_DELAY + 1);
    localparam int DCW   = (LW > fed_pkg::DELAY_W) ? LW : fed_pkg::DELAY_W;
    localparam int MW    = SAMPLE_BITS + 17;
    localparam int FW    = SAMPLE_BITS + 16;

    logic [fed_pkg::DELAY_W-1:0] delay_samples_reg;
    logic [fed_pkg::FB_W-1:0]    feedback_gain_reg;
    logic [fed_pkg::MIX_W-1:0]   mix_gain_reg;

    logic            clear_busy_reg;
    logic [AW-1:0]   clear_addr_reg;
    logic [PW-1:0]   wp_reg [fed_pkg::CH_SLOTS];

    logic            v1_reg;
    logic            v2_reg;
    logic            out_valid_reg;
    logic            v1_next;
    logic            v2_next;
    logic            out_valid_next;

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] mem_rdata_reg;

    logic signed [SAMPLE_BITS-1:0] x1_reg;
    logic [AW-1:0]                 rd_addr1_reg;
    logic [AW-1:0]                 wr_addr1_reg;
    logic                          byp1_reg;
    logic signed [SAMPLE_BITS-1:0] bypd1_reg;

    logic signed [MW-1:0]          wet2_reg;
    logic signed [MW-1:0]          dry2_reg;
    logic signed [FW-1:0]          fb2_reg;
    logic signed [SAMPLE_BITS-1:0] x2_reg;
    logic [AW-1:0]                 wr_addr2_reg;

    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    logic                          ready_2;
    logic                          ready_1;
    logic                          s1_adv;
    logic                          wr_fire;
    logic                          in_fire;

    logic                          ch_eff;
    logic [PW-1:0]                 wp_cur;
    logic [PW-1:0]                 wp_inc;
    logic [DCW-1:0]                d_wide;
    logic [LW-1:0]                 d_eff;
    logic [LW:0]                   wp_ext;
    logic [LW:0]                   d_ext;
    logic [LW:0]                   wrap_pos;
    logic [PW-1:0]                 rd_pos;
    logic [AW-1:0]                 base_addr;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;

    logic [fed_pkg::FB_W-1:0]      fb_eff;
    logic [fed_pkg::MIX_W-1:0]     mix_eff;
    logic [fed_pkg::MIX_W-1:0]     dry_gain;
    logic signed [SAMPLE_BITS-1:0] dly;
    logic signed [MW-1:0]          dly_ext;
    logic signed [MW-1:0]          x_ext;
    logic signed [MW-1:0]          mix_ext;
    logic signed [MW-1:0]          dry_ext;
    logic signed [FW-1:0]          dlyf_ext;
    logic signed [FW-1:0]          fb_ext;

    logic signed [SAMPLE_BITS-1:0] mix_sample;
    logic signed [SAMPLE_BITS-1:0] store_sample;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic signed [SAMPLE_BITS-1:0] mem_wdata;

    assign ready_2  = !out_valid_reg || !out_stall;
    assign ready_1  = !v2_reg || ready_2;
    assign s1_adv   = v1_reg && ready_1;
    assign wr_fire  = v2_reg && ready_2;
    assign in_stall = clear_busy_reg || (v1_reg && !ready_1);
    assign in_fire  = in_valid && !in_stall;

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    assign ch_eff = (NCH > 1) ? channel_index : 1'b0;
    assign wp_cur = wp_reg[ch_eff];
    assign wp_inc = (wp_cur == PW'(MAX_DELAY - 1)) ? '0 : wp_cur + PW'(1);

    assign d_wide = DCW'(delay_samples_reg);

    always_comb
    begin
        if (d_wide == '0)
        begin
            d_eff = LW'(1);
        end
        else if (d_wide > DCW'(MAX_DELAY))
        begin
            d_eff = LW'(MAX_DELAY);
        end
        else
        begin
            d_eff = LW'(d_wide);
        end
    end

    assign wp_ext   = (LW+1)'(wp_cur);
    assign d_ext    = (LW+1)'(d_eff);
    assign wrap_pos = wp_ext + (LW+1)'(MAX_DELAY) - d_ext;
    assign rd_pos   = (wp_ext >= d_ext) ? PW'(wp_ext - d_ext) : PW'(wrap_pos);

    assign base_addr = ch_eff ? AW'(MAX_DELAY) : '0;
    assign rd_addr   = base_addr + AW'(rd_pos);
    assign wr_addr   = base_addr + AW'(wp_cur);

    assign fb_eff   = (feedback_gain_reg > fed_pkg::FB_CAP) ? fed_pkg::FB_CAP
                                                            : feedback_gain_reg;
    assign mix_eff  = (mix_gain_reg > fed_pkg::UNITY) ? fed_pkg::UNITY : mix_gain_reg;
    assign dry_gain = fed_pkg::UNITY - mix_eff;

    always_comb
    begin
        if (v2_reg && (wr_addr2_reg == rd_addr1_reg))
        begin
            dly = store_sample;
        end
        else if (byp1_reg)
        begin
            dly = bypd1_reg;
        end
        else
        begin
            dly = mem_rdata_reg;
        end
    end

    assign dly_ext  = MW'(dly);
    assign x_ext    = MW'(x1_reg);
    assign mix_ext  = MW'($signed({1'b0, mix_eff}));
    assign dry_ext  = MW'($signed({1'b0, dry_gain}));
    assign dlyf_ext = FW'(dly);
    assign fb_ext   = FW'($signed({1'b0, fb_eff}));

    fed_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .wet_prod     (wet2_reg),
        .dry_prod     (dry2_reg),
        .fb_prod      (fb2_reg),
        .dry_sample   (x2_reg),
        .mix_sample   (mix_sample),
        .store_sample (store_sample)
    );

    assign mem_we    = clear_busy_reg || wr_fire;
    assign mem_waddr = clear_busy_reg ? clear_addr_reg : wr_addr2_reg;
    assign mem_wdata = clear_busy_reg ? '0 : store_sample;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire)
        begin
            mem_rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_samples_reg <= fed_pkg::DELAY_RESET;
            feedback_gain_reg <= fed_pkg::FEEDBACK_RESET;
            mix_gain_reg      <= fed_pkg::MIX_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fed_pkg::REG_DELAY:
                begin
                    delay_samples_reg <= cfg_data[fed_pkg::DELAY_W-1:0];
                end
                fed_pkg::REG_FEEDBACK:
                begin
                    feedback_gain_reg <= cfg_data[fed_pkg::FB_W-1:0];
                end
                fed_pkg::REG_MIX:
                begin
                    mix_gain_reg <= cfg_data[fed_pkg::MIX_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            if (clear_addr_reg == AW'(DEPTH - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
            else
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fed_pkg::CH_SLOTS; i++)
            begin
                wp_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            wp_reg[ch_eff] <= wp_inc;
        end
    end

    always_comb
    begin
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        out_valid_next = out_valid_reg;
        if (ready_2)
        begin
            out_valid_next = v2_reg;
        end
        if (ready_1)
        begin
            v2_next = v1_reg;
        end
        if (in_fire)
        begin
            v1_next = 1'b1;
        end
        else if (s1_adv)
        begin
            v1_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x1_reg       <= sample_in;
            rd_addr1_reg <= rd_addr;
            wr_addr1_reg <= wr_addr;
            byp1_reg     <= wr_fire && (wr_addr2_reg == rd_addr);
            bypd1_reg    <= store_sample;
        end
        if (s1_adv)
        begin
            wet2_reg     <= mix_ext * dly_ext;
            dry2_reg     <= dry_ext * x_ext;
            fb2_reg      <= fb_ext * dlyf_ext;
            x2_reg       <= x1_reg;
            wr_addr2_reg <= wr_addr1_reg;
        end
        if (wr_fire)
        begin
            sample_out_reg <= mix_sample;
        end
    end

`ifndef ASSERT_OFF
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> in_stall)
        else $error("input taken during memory sweep");

    a_clear_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !(v1_reg || v2_reg || out_valid_reg))
        else $error("pipeline occupied during memory sweep");

    a_distinct_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg) |-> (wr_addr1_reg != wr_addr2_reg))
        else $error("adjacent items target the same store entry");

    a_fire_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (v1_reg && (wr_addr1_reg == $past(wr_addr))))
        else $error("accepted item lost at first stage");
`endif

endmodule

FILE: rtl/fed_mix.sv
// fed_mix: rounding, feedback sum and saturation of the registered products.
// Produces the mixed output sample and the value written back to the store.
// Depends on fed_pkg.
module fed_mix #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS+16:0] wet_prod,
    input  logic signed [SAMPLE_BITS+16:0] dry_prod,
    input  logic signed [SAMPLE_BITS+15:0] fb_prod,
    input  logic signed [SAMPLE_BITS-1:0]  dry_sample,
    output logic signed [SAMPLE_BITS-1:0]  mix_sample,
    output logic signed [SAMPLE_BITS-1:0]  store_sample
);

    localparam int MW = SAMPLE_BITS + 17;
    localparam int SW = MW + 1;
    localparam int FW = SAMPLE_BITS + 16;
    localparam int GW = FW + 1;

    localparam logic signed [SW-1:0] Y_HI = {{(SW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] Y_LO = ~Y_HI;
    localparam logic signed [GW-1:0] W_HI = {{(GW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [GW-1:0] W_LO = ~W_HI;

    logic signed [SW-1:0] mix_sum;
    logic signed [SW-1:0] mix_round;
    logic signed [GW-1:0] fb_sum;
    logic signed [GW-1:0] fb_round;
    logic signed [GW-1:0] store_sum;

    assign mix_sum   = SW'(wet_prod) + SW'(dry_prod) + SW'(fed_pkg::ROUND_BIAS);
    assign mix_round = mix_sum >>> fed_pkg::Q_SHIFT;
    assign fb_sum    = GW'(fb_prod) + GW'(fed_pkg::ROUND_BIAS);
    assign fb_round  = fb_sum >>> fed_pkg::Q_SHIFT;
    assign store_sum = fb_round + GW'(dry_sample);

    always_comb
    begin
        if (mix_round > Y_HI)
        begin
            mix_sample = Y_HI[SAMPLE_BITS-1:0];
        end
        else if (mix_round < Y_LO)
        begin
            mix_sample = Y_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            mix_sample = mix_round[SAMPLE_BITS-1:0];
        end
    end

    always_comb
    begin
        if (store_sum > W_HI)
        begin
            store_sample = W_HI[SAMPLE_BITS-1:0];
        end
        else if (store_sum < W_LO)
        begin
            store_sample = W_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            store_sample = store_sum[SAMPLE_BITS-1:0];
        end
    end

endmodule
